// ----- src/itdc_pkg.sv -----
// Shared types, constants and the arctangent table for the IMU tilt block.
`default_nettype none
package itdc_pkg;

  // field widths
  localparam int AW   = 17;  // raw acceleration
  localparam int RW   = 16;  // angular rate
  localparam int HW   = 18;  // held values and angles
  localparam int AOW  = 17;  // angle offset
  localparam int SW   = 25;  // calibration sums
  localparam int CCW  = 8;   // calibration count
  localparam int ADW  = 16;  // acceleration deadband
  localparam int GDW  = 17;  // angle deadband
  localparam int CFGW = 17;  // config write data
  localparam int IN_W  = 88;
  localparam int OUT_W = 112;

  // CORDIC datapath
  localparam int CW   = 28;  // x/y word
  localparam int ZW   = 26;  // angle accumulator, 1/65536 degree
  localparam int ATW  = 22;  // table entry width
  localparam int ITER_MAX     = 24;
  localparam int ITERS_DEF    = 16;
  localparam int TAB_IDX_W    = 5;
  localparam logic signed [ZW-1:0] Z_90  = 26'sd5898240;
  localparam logic signed [HW-1:0] ANG_MAX = 18'sd46080;
  localparam logic [15:0] HYP_GAIN = 16'd39797;

  // divider
  localparam int NW  = 28;   // numerator magnitude
  localparam int DNW = 11;   // divisor
  localparam logic [13:0] GRAV_UNITS = 14'd12544;  // 9.8 m/s^2 times 5, in 1/256 units
  localparam logic [2:0]  DIV_LAST   = 3'd5;       // six offsets per calibration run
  localparam logic [2:0]  DIV_ACC_Z  = 3'd2;

  // config register indexes
  typedef enum logic [1:0] {
    REG_CAL_COUNT = 2'd0,
    REG_ACCEL_DB  = 2'd1,
    REG_ANGLE_DB  = 2'd2
  } reg_e;

  localparam logic [CCW-1:0] CAL_COUNT_RST = 8'd10;
  localparam logic [ADW-1:0] ACCEL_DB_RST  = 16'd26;
  localparam logic [GDW-1:0] ANGLE_DB_RST  = 17'd1280;

  typedef enum logic [1:0] {
    PASS_PITCH = 2'd0,
    PASS_MAG   = 2'd1,
    PASS_ROLL  = 2'd2,
    PASS_YAW   = 2'd3
  } pass_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC_GO,
    ST_CORDIC_WAIT,
    ST_HYP,
    ST_UPDATE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_CAL_CLR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       in_load;
    logic       cordic_start;
    pass_e      pass;
    logic       capture;
    logic       hyp_load;
    logic       update;
    logic       div_start;
    logic [2:0] div_sel;
    logic       div_capture;
    logic       cal_clear;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic div_done;
    logic cal_end;
  } dp_sts_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic [ATW-1:0] atan_lut(input logic [TAB_IDX_W-1:0] i);
    logic [ATW-1:0] r;
    unique case (i)
      5'd0:  r = 22'd2949120;
      5'd1:  r = 22'd1740967;
      5'd2:  r = 22'd919879;
      5'd3:  r = 22'd466945;
      5'd4:  r = 22'd234379;
      5'd5:  r = 22'd117304;
      5'd6:  r = 22'd58666;
      5'd7:  r = 22'd29335;
      5'd8:  r = 22'd14668;
      5'd9:  r = 22'd7334;
      5'd10: r = 22'd3667;
      5'd11: r = 22'd1833;
      5'd12: r = 22'd917;
      5'd13: r = 22'd458;
      5'd14: r = 22'd229;
      5'd15: r = 22'd115;
      5'd16: r = 22'd57;
      5'd17: r = 22'd29;
      5'd18: r = 22'd14;
      5'd19: r = 22'd7;
      5'd20: r = 22'd4;
      5'd21: r = 22'd2;
      5'd22: r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/itdc_cordic.sv -----
// Iterative vectoring CORDIC: one micro-rotation per cycle.
`default_nettype none
module itdc_cordic
  import itdc_pkg::*;
#(
  parameter int ITERS = ITERS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic signed [CW-1:0] x_i,
  input  wire logic signed [CW-1:0] y_i,
  output logic                      done_o,
  output logic signed [CW-1:0]      x_o,
  output logic signed [ZW-1:0]      z_o
);

  localparam int ITER_N = (ITERS > ITER_MAX) ? ITER_MAX : ITERS;
  localparam int IW = $clog2(ITER_N);
  localparam logic [IW-1:0] LAST = IW'(ITER_N - 1);

  logic          busy_q, done_q;
  logic [IW-1:0] iter_q;
  logic signed [CW-1:0] x_q, y_q, xs, ys;
  logic signed [ZW-1:0] z_q, at;

  assign xs = x_q >>> iter_q;
  assign ys = y_q >>> iter_q;
  assign at = $signed(ZW'(atan_lut(TAB_IDX_W'(iter_q))));

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= busy_q && (iter_q == LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        if (iter_q == LAST) busy_q <= 1'b0;
        iter_q <= iter_q + 1'b1;
      end
    end
  end

  // pre-rotation into the right half plane, then micro-rotations
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_q <= y_i;
          y_q <= -x_i;
          z_q <= Z_90;
        end else begin
          x_q <= -y_i;
          y_q <= x_i;
          z_q <= -Z_90;
        end
      end else begin
        x_q <= x_i;
        y_q <= y_i;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (y_q >= 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign z_o    = z_q;

endmodule
`default_nettype wire

// ----- src/itdc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module itdc_div
  import itdc_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [NW-1:0]  num_i,
  input  wire logic [DNW-1:0] den_i,
  output logic                done_o,
  output logic [NW-1:0]       quo_o
);

  localparam int CNW = $clog2(NW);
  localparam logic [CNW-1:0] LAST = CNW'(NW - 1);

  logic           busy_q, done_q;
  logic [CNW-1:0] cnt_q;
  logic [DNW-1:0] rem_q, den_q;
  logic [NW-1:0]  quo_q;
  logic [DNW:0]   trial;
  logic           ge;

  assign trial = {rem_q, quo_q[NW-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == LAST) busy_q <= 1'b0;
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // shift in one numerator bit, subtract when it fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? DNW'(trial - {1'b0, den_q}) : DNW'(trial);
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// ----- src/itdc_ctrl.sv -----
// Sequencing state machine: CORDIC passes, update, calibration divides, output.
`default_nettype none
module itdc_ctrl
  import itdc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  state_e     state_q, state_d;
  pass_e      pass_q, pass_d;
  logic [2:0] div_q, div_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    div_d   = div_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CORDIC_GO;
          pass_d  = PASS_PITCH;
        end
      end
      ST_CORDIC_GO: state_d = ST_CORDIC_WAIT;
      ST_CORDIC_WAIT: begin
        if (sts_i.cordic_done) begin
          if (pass_q == PASS_YAW) begin
            state_d = ST_UPDATE;
          end else begin
            state_d = (pass_q == PASS_MAG) ? ST_HYP : ST_CORDIC_GO;
            pass_d  = pass_e'(pass_q + 2'd1);
          end
        end
      end
      ST_HYP: state_d = ST_CORDIC_GO;
      ST_UPDATE: begin
        state_d = sts_i.cal_end ? ST_DIV_GO : ST_DONE;
        div_d   = '0;
      end
      ST_DIV_GO: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (sts_i.div_done) begin
          if (div_q == DIV_LAST) begin
            state_d = ST_CAL_CLR;
          end else begin
            state_d = ST_DIV_GO;
            div_d   = div_q + 3'd1;
          end
        end
      end
      ST_CAL_CLR: state_d = ST_DONE;
      ST_DONE: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o              = '0;
    cmd_o.pass         = pass_q;
    cmd_o.div_sel      = div_q;
    cmd_o.in_load      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.cordic_start = (state_q == ST_CORDIC_GO);
    cmd_o.capture      = (state_q == ST_CORDIC_WAIT) && sts_i.cordic_done;
    cmd_o.hyp_load     = (state_q == ST_HYP);
    cmd_o.update       = (state_q == ST_UPDATE);
    cmd_o.div_start    = (state_q == ST_DIV_GO);
    cmd_o.div_capture  = (state_q == ST_DIV_WAIT) && sts_i.div_done;
    cmd_o.cal_clear    = (state_q == ST_CAL_CLR);
    cmd_o.out_load     = (state_q == ST_DONE) && slot_free;
  end

  // output word valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load)   out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= PASS_PITCH;
      div_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      div_q       <= div_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- src/itdc_dp.sv -----
// Datapath: input latch, CORDIC, hypot scaling, deadband update, calibration.
`default_nettype none
module itdc_dp
  import itdc_pkg::*;
#(
  parameter int ITERS = ITERS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [IN_W-1:0]  in_data_i,
  input  wire logic             in_user_i,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_addr_i,
  input  wire logic [CFGW-1:0]  cfg_wdata_i,
  input  wire dp_cmd_t          cmd_i,
  output dp_sts_t               sts_o,
  output logic [OUT_W-1:0]      out_data_o
);

  function automatic logic signed [CW-1:0] sc_a(input logic signed [AW-1:0] v);
    return $signed({{(CW-AW-8){v[AW-1]}}, v, 8'd0});
  endfunction

  function automatic logic signed [CW-1:0] sc_r(input logic signed [RW-1:0] v);
    return $signed({{(CW-RW-8){v[RW-1]}}, v, 8'd0});
  endfunction

  function automatic logic signed [CW-1:0] sc_abs(input logic signed [AW-1:0] v);
    logic signed [AW:0] e;
    e = {v[AW-1], v};
    if (e < 0) e = -e;
    return $signed({{(CW-AW-9){1'b0}}, e, 8'd0});
  endfunction

  // configuration
  logic [CCW-1:0] cal_cnt_q;
  logic [ADW-1:0] accel_db_q;
  logic [GDW-1:0] angle_db_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_cnt_q  <= CAL_COUNT_RST;
      accel_db_q <= ACCEL_DB_RST;
      angle_db_q <= ANGLE_DB_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_CAL_COUNT: cal_cnt_q  <= cfg_wdata_i[CCW-1:0];
        REG_ACCEL_DB:  accel_db_q <= cfg_wdata_i[ADW-1:0];
        REG_ANGLE_DB:  angle_db_q <= cfg_wdata_i[GDW-1:0];
        default: ;
      endcase
    end
  end

  // input word latch
  logic                 cmd_q;
  logic signed [AW-1:0] acc_q [3];
  logic signed [RW-1:0] rx_q, ry_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      cmd_q    <= in_user_i;
      acc_q[0] <= $signed(in_data_i[16:0]);
      acc_q[1] <= $signed(in_data_i[33:17]);
      acc_q[2] <= $signed(in_data_i[50:34]);
      rx_q     <= $signed(in_data_i[66:51]);
      ry_q     <= $signed(in_data_i[82:67]);
    end
  end

  // CORDIC operand select
  logic signed [CW-1:0] cx, cy, c_x;
  logic signed [ZW-1:0] c_z;
  logic signed [CW-1:0] mag_q, hyp_q;
  logic                 c_done;

  always_comb begin
    unique case (cmd_i.pass)
      PASS_PITCH: begin cx = sc_a(acc_q[2]);   cy = sc_a(acc_q[1]);   end
      PASS_MAG:   begin cx = sc_abs(acc_q[2]); cy = sc_abs(acc_q[1]); end
      PASS_ROLL:  begin cx = hyp_q;            cy = -sc_a(acc_q[0]);  end
      PASS_YAW:   begin cx = sc_r(rx_q);       cy = sc_r(ry_q);       end
      default:    begin cx = '0;               cy = '0;               end
    endcase
  end

  itdc_cordic #(.ITERS(ITERS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.cordic_start),
    .x_i     (cx),
    .y_i     (cy),
    .done_o  (c_done),
    .x_o     (c_x),
    .z_o     (c_z)
  );

  // round to 1/256 degree and clamp to +-180 degrees
  logic signed [ZW-1:0] z_rnd;
  logic signed [HW-1:0] r_ang, r_clamp;
  logic                 zero_vec;

  assign z_rnd = c_z + ZW'(128);
  assign r_ang = HW'(z_rnd >>> 8);

  always_comb begin
    if (r_ang > ANG_MAX)       r_clamp = ANG_MAX;
    else if (r_ang < -ANG_MAX) r_clamp = -ANG_MAX;
    else                       r_clamp = r_ang;
    unique case (cmd_i.pass)
      PASS_PITCH: zero_vec = (acc_q[1] == 0) && (acc_q[2] == 0);
      PASS_ROLL:  zero_vec = (hyp_q == 0) && (acc_q[0] == 0);
      PASS_YAW:   zero_vec = (rx_q == 0) && (ry_q == 0);
      default:    zero_vec = 1'b0;
    endcase
  end

  // angle capture and hypot gain correction
  logic signed [HW-1:0] ang_q [3];
  logic [CW+15:0]       hyp_prod;

  assign hyp_prod = ({16'd0, mag_q} * {{CW{1'b0}}, HYP_GAIN}) + (CW+16)'(32768);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      unique case (cmd_i.pass)
        PASS_PITCH: ang_q[0] <= zero_vec ? '0 : r_clamp;
        PASS_MAG:   mag_q    <= c_x;
        PASS_ROLL:  ang_q[1] <= zero_vec ? '0 : r_clamp;
        PASS_YAW:   ang_q[2] <= zero_vec ? '0 : r_clamp;
        default: ;
      endcase
    end
    if (cmd_i.hyp_load) hyp_q <= $signed(hyp_prod[CW+15:16]);
  end

  // deadband update candidates
  logic signed [HW-1:0]  held_acc_q [3];
  logic signed [HW-1:0]  held_ang_q [3];
  logic signed [HW-1:0]  acc_off_q  [3];
  logic signed [AOW-1:0] ang_off_q  [3];
  logic signed [SW-1:0]  acc_sum_q  [3];
  logic signed [SW-1:0]  ang_sum_q  [3];
  logic [CCW-1:0]        count_q;
  logic                  cal_done_q;

  logic signed [HW-1:0] acc_new [3];
  logic signed [HW-1:0] ang_new [3];
  logic                 acc_take [3];
  logic                 ang_take [3];

  always_comb begin
    logic signed [HW:0]   d;
    logic signed [HW+1:0] dv;
    logic signed [HW:0]   g, dg;
    for (int i = 0; i < 3; i++) begin
      d = {{2{acc_q[i][AW-1]}}, acc_q[i]} - {acc_off_q[i][HW-1], acc_off_q[i]};
      if (d > (HW+1)'(131071))       acc_new[i] = 18'sd131071;
      else if (d < -(HW+1)'(131072)) acc_new[i] = -18'sd131072;
      else                           acc_new[i] = HW'(d);
      dv = {{2{acc_new[i][HW-1]}}, acc_new[i]} - {{2{held_acc_q[i][HW-1]}}, held_acc_q[i]};
      if (dv < 0) dv = -dv;
      acc_take[i] = dv > $signed({4'd0, accel_db_q});
      g  = {ang_q[i][HW-1], ang_q[i]} - {{2{ang_off_q[i][AOW-1]}}, ang_off_q[i]};
      ang_new[i] = HW'(g);
      dg = g - {held_ang_q[i][HW-1], held_ang_q[i]};
      if (dg < 0) dg = -dg;
      ang_take[i] = dg > $signed({2'd0, angle_db_q});
    end
  end

  // calibration bookkeeping
  logic [CCW-1:0] n_eff, count_inc;
  logic           cal_end;

  assign n_eff     = (cal_cnt_q == '0) ? CCW'(1) : cal_cnt_q;
  assign count_inc = count_q + 1'b1;
  assign cal_end   = cmd_q && (count_inc >= n_eff);

  // divider operands with round half away from zero
  logic signed [NW-1:0] num_s;
  logic [DNW-1:0]       den;
  logic [NW-1:0]        num_mag, quo;
  logic                 neg_q, d_done;
  logic signed [NW-1:0] q_s;

  always_comb begin
    unique case (cmd_i.div_sel)
      3'd0: num_s = NW'(acc_sum_q[0]);
      3'd1: num_s = NW'(acc_sum_q[1]);
      3'd2: num_s = (NW'(acc_sum_q[2]) <<< 2) + NW'(acc_sum_q[2])
                    - $signed(NW'(GRAV_UNITS * n_eff));
      3'd3: num_s = NW'(ang_sum_q[0]);
      3'd4: num_s = NW'(ang_sum_q[1]);
      3'd5: num_s = NW'(ang_sum_q[2]);
      default: num_s = '0;
    endcase
    den     = (cmd_i.div_sel == DIV_ACC_Z) ? DNW'(n_eff * 3'd5) : DNW'(n_eff);
    num_mag = ((num_s < 0) ? NW'(-num_s) : NW'(num_s)) + NW'(den >> 1);
  end

  itdc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_mag),
    .den_i   (den),
    .done_o  (d_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) neg_q <= num_s < 0;
  end

  assign q_s = neg_q ? -$signed(quo) : $signed(quo);

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        held_acc_q[i] <= '0;
        held_ang_q[i] <= '0;
        acc_off_q[i]  <= '0;
        ang_off_q[i]  <= '0;
        acc_sum_q[i]  <= '0;
        ang_sum_q[i]  <= '0;
      end
      count_q    <= '0;
      cal_done_q <= 1'b0;
    end else begin
      if (cmd_i.update) begin
        if (!cmd_q) begin
          for (int i = 0; i < 3; i++) begin
            if (acc_take[i]) held_acc_q[i] <= acc_new[i];
            if (ang_take[i]) held_ang_q[i] <= ang_new[i];
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            acc_sum_q[i] <= acc_sum_q[i] + SW'(acc_q[i]);
            ang_sum_q[i] <= ang_sum_q[i] + SW'(ang_q[i]);
          end
          count_q <= count_inc;
        end
      end
      if (cmd_i.div_capture) begin
        unique case (cmd_i.div_sel)
          3'd0: acc_off_q[0] <= HW'(q_s);
          3'd1: acc_off_q[1] <= HW'(q_s);
          3'd2: acc_off_q[2] <= HW'(q_s);
          3'd3: ang_off_q[0] <= AOW'(q_s);
          3'd4: ang_off_q[1] <= AOW'(q_s);
          3'd5: ang_off_q[2] <= AOW'(q_s);
          default: ;
        endcase
      end
      if (cmd_i.cal_clear) begin
        for (int i = 0; i < 3; i++) begin
          acc_sum_q[i] <= '0;
          ang_sum_q[i] <= '0;
        end
        count_q    <= '0;
        cal_done_q <= 1'b1;
      end
    end
  end

  // result word register
  logic [OUT_W-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= {3'd0, cal_done_q, held_ang_q[2], held_ang_q[1], held_ang_q[0],
                held_acc_q[2], held_acc_q[1], held_acc_q[0]};
    end
  end

  assign sts_o      = '{cordic_done: c_done, div_done: d_done, cal_end: cal_end};
  assign out_data_o = out_q;

endmodule
`default_nettype wire

// ----- src/imu_tilt_deadband_calibrated.sv -----
// Top level: IMU tilt angles with deadband hold and offset calibration.
//
// Input stream (s_axis): one word per IMU sample; tuser selects measure (0)
// or calibration sample (1). Output stream (m_axis): one word per input word
// carrying the held accelerations, held pitch/roll/yaw and the calibrated flag.
// Config port: cfg_we_i writes register cfg_addr_i (0 calibration count,
// 1 acceleration deadband, 2 angle deadband) at the clock edge.
//
// Each word runs four passes through one shared iterative CORDIC, plus
// hypot scaling, update and output load. The word that ends a
// calibration run adds six serial divides and a step to clear the sums.
// One word is in flight at a time; the next is taken as soon as the result
// is parked in the output register, even if m_axis is still stalled.
// A stalled receiver holds the finished word; the block then waits before
// loading a second result. Reset clears all held values, offsets, sums and
// the calibrated flag, and restores the register defaults.
`default_nettype none
module imu_tilt_deadband_calibrated
  import itdc_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = ITERS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  // command
  input  wire logic             s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // held_accel_x/y/z, held_pitch, held_roll, held_yaw, calibrated
  output logic [OUT_W-1:0]      m_axis_tdata,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_addr_i,
  input  wire logic [CFGW-1:0]  cfg_wdata_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  itdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  itdc_dp #(.ITERS(CORDIC_ITERATIONS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // a loaded result is offered next cycle
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> m_axis_tvalid) else $error("result not offered after load");

  // an accepted word blocks further input while it is processed
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while busy");

  // end of a calibration run starts the offset divides
  a_cal_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.update && sts.cal_end) |=> cmd.div_start)
    else $error("calibration end without divide");
`endif

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
// Self-checking testbench for the IMU tilt, deadband and calibration block.
`default_nettype none
module testbench;
  import itdc_pkg::*;

  typedef struct {
    logic                 cmd;
    logic signed [16:0]   acc [3];
    logic signed [15:0]   rx;
    logic signed [15:0]   ry;
  } sample_t;

  typedef struct {
    logic signed [17:0] accel [3];
    logic signed [17:0] angle [3];
    logic               cal;
  } held_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_addr_i = 2'd0;
  logic [CFGW-1:0] cfg_wdata_i = '0;

  imu_tilt_deadband_calibrated DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state and its copy of the registers
  longint held_acc [3], held_ang [3], acc_off [3], ang_off [3], acc_sum [3], ang_sum [3];
  int unsigned cal_samples, cal_flag;
  int unsigned cal_count_r, accel_db_r, angle_db_r;

  const longint arctan_q16 [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
    58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  sample_t pending_samples [$];
  held_t   expected_outputs [$];
  int errors = 0;
  int n_measure = 0, n_cal = 0, n_results = 0, n_cal_runs = 0;

  function automatic longint vec_angle(longint x, longint y, output longint mag);
    longint z, t, xs, ys;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 90 * 65536;
      end else begin
        t = x; x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += arctan_q16[i];
      end else begin
        x -= ys; y += xs; z -= arctan_q16[i];
      end
    end
    mag = x;
    return z;
  endfunction

  // rounds a 1/65536 degree angle to 1/256 degree and clamps to +-180
  function automatic longint to_deg256(longint z);
    longint r;
    r = (z + 128) >>> 8;
    if (r > 46080) r = 46080;
    if (r < -46080) r = -46080;
    return r;
  endfunction

  function automatic longint atan2_deg256(longint y, longint x);
    longint m;
    if (x == 0 && y == 0) return 0;
    return to_deg256(vec_angle(x * 256, y * 256, m));
  endfunction

  function automatic longint rnd_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // works out the word the block must return for one accepted sample
  function automatic held_t tilt_predict(sample_t s);
    longint a [3], ang [3], mag, hyp, v, g, n, unused;
    held_t r;
    for (int i = 0; i < 3; i++) a[i] = s.acc[i];
    ang[0] = atan2_deg256(a[1], a[2]);
    unused = vec_angle(abs64(a[2]) * 256, abs64(a[1]) * 256, mag);
    hyp = (mag * 39797 + 32768) >>> 16;
    if (hyp == 0 && a[0] == 0) ang[1] = 0;
    else ang[1] = to_deg256(vec_angle(hyp, -a[0] * 256, unused));
    ang[2] = atan2_deg256(longint'(s.ry), longint'(s.rx));
    if (s.cmd == 1'b0) begin
      for (int i = 0; i < 3; i++) begin
        v = a[i] - acc_off[i];
        if (v > 131071) v = 131071;
        if (v < -131072) v = -131072;
        g = ang[i] - ang_off[i];
        if (abs64(v - held_acc[i]) > accel_db_r) held_acc[i] = v;
        if (abs64(g - held_ang[i]) > angle_db_r) held_ang[i] = g;
      end
    end else begin
      n = (cal_count_r == 0) ? 1 : cal_count_r;
      for (int i = 0; i < 3; i++) begin
        acc_sum[i] += a[i];
        ang_sum[i] += ang[i];
      end
      cal_samples = (cal_samples + 1) & 8'hFF;
      if (cal_samples >= n) begin
        acc_off[0] = rnd_div(acc_sum[0], n);
        acc_off[1] = rnd_div(acc_sum[1], n);
        acc_off[2] = rnd_div(5 * acc_sum[2] - 12544 * n, 5 * n);
        for (int i = 0; i < 3; i++) begin
          ang_off[i] = rnd_div(ang_sum[i], n);
          acc_sum[i] = 0;
          ang_sum[i] = 0;
        end
        cal_samples = 0;
        cal_flag = 1;
        n_cal_runs++;
      end
    end
    for (int i = 0; i < 3; i++) begin
      r.accel[i] = held_acc[i][17:0];
      r.angle[i] = held_ang[i][17:0];
    end
    r.cal = cal_flag[0];
    return r;
  endfunction

  // sender: bursts of random length separated by random gaps
  int burst_left = 0, gap_left = 0;
  sample_t cur;
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      expected_outputs.push_back(tilt_predict(cur));
      if (cur.cmd) n_cal++;
      else n_measure++;
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        cur = pending_samples.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cur.cmd;
        s_axis_tdata <= {5'b0, cur.ry, cur.rx, cur.acc[2], cur.acc[1], cur.acc[0]};
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stalls in modes that change now and then
  int stall_mode = 0;
  held_t got, want;
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      n_results++;
      for (int i = 0; i < 3; i++) begin
        got.accel[i] = m_axis_tdata[18*i +: 18];
        got.angle[i] = m_axis_tdata[54 + 18*i +: 18];
      end
      got.cal = m_axis_tdata[108];
      if (expected_outputs.size() == 0) begin
        $display("%0t: unexpected word, actual %p", $time, got);
        errors++;
      end else begin
        want = expected_outputs.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got.accel[i] !== want.accel[i]) begin
            $display("%0t: held_accel[%0d] expected %0d actual %0d", $time, i,
                     want.accel[i], got.accel[i]);
            errors++;
          end
          if (got.angle[i] !== want.angle[i]) begin
            $display("%0t: held_angle[%0d] expected %0d actual %0d", $time, i,
                     want.angle[i], got.angle[i]);
            errors++;
          end
        end
        if (got.cal !== want.cal) begin
          $display("%0t: calibrated expected %0b actual %0b", $time, want.cal, got.cal);
          errors++;
        end
      end
    end
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= ($urandom_range(0, 150) == 0) ? 1'b1 : 1'b0;
    endcase
  end

  task automatic add_sample(logic c, int ax, int ay, int az, int rx, int ry);
    sample_t s;
    s.cmd = c;
    s.acc[0] = 17'(ax); s.acc[1] = 17'(ay); s.acc[2] = 17'(az);
    s.rx = 16'(rx); s.ry = 16'(ry);
    pending_samples.push_back(s);
  endtask

  task automatic reg_write(reg_e idx, int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= CFGW'(val);
    case (idx)
      REG_CAL_COUNT: cal_count_r = val & 8'hFF;
      REG_ACCEL_DB:  accel_db_r = val & 16'hFFFF;
      default:       angle_db_r = val & 17'h1FFFF;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || s_axis_tvalid || expected_outputs.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // mostly near-level readings, some anywhere in range
  task automatic add_random(logic c);
    if ($urandom_range(0, 9) < 6)
      add_sample(c, $urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                 2509 + $urandom_range(0, 1000) - 500,
                 $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
    else
      add_sample(c, $urandom_range(0, 131071) - 65536, $urandom_range(0, 131071) - 65536,
                 $urandom_range(0, 131071) - 65536,
                 $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
  endtask

  int unsigned phase_cfg [5][5] = '{
    '{1, 0, 0, 110, 30},
    '{0, 65535, 131071, 60, 50},
    '{7, 200, 800, 150, 40},
    '{255, 26, 92160, 280, 95},
    '{4, 5, 100, 110, 30}
  };

  initial begin
    for (int i = 0; i < 3; i++) begin
      held_acc[i] = 0; held_ang[i] = 0; acc_off[i] = 0;
      ang_off[i] = 0; acc_sum[i] = 0; ang_sum[i] = 0;
    end
    cal_samples = 0; cal_flag = 0;
    cal_count_r = 10; accel_db_r = 26; angle_db_r = 1280;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, zero vectors, the +180 corner, one full calibration, then three measures
    add_sample(0, 0, 0, 0, 0, 0);
    add_sample(0, 65535, 65535, 65535, 32767, 32767);
    add_sample(0, -65536, -65536, -65536, -32768, -32768);
    add_sample(0, 0, 0, -2000, -5, 0);
    add_sample(0, -300, 0, -65536, -32768, 0);
    add_sample(0, 65535, 0, 0, 0, 32767);
    add_sample(0, -65536, 65535, 0, 32767, -32768);
    add_sample(0, 0, -65536, 1, 1, -1);
    for (int i = 0; i < 10; i++) add_sample(1, 100 - i, -50 + i, 2509 + 3 * i, 10, 20);
    add_sample(0, 65535, -65536, -65536, 0, 0);
    add_sample(0, -65536, 65535, 65535, 0, 0);
    add_sample(0, 120, -40, 2600, 100, -100);
    drain();

    foreach (phase_cfg[p]) begin
      reg_write(REG_CAL_COUNT, phase_cfg[p][0]);
      reg_write(REG_ACCEL_DB, phase_cfg[p][1]);
      reg_write(REG_ANGLE_DB, phase_cfg[p][2]);
      for (int k = 0; k < phase_cfg[p][3]; k++)
        add_random($urandom_range(0, 99) < phase_cfg[p][4]);
      drain();
    end

    repeat (300) @(posedge clk_i);
    $display("Covered %0d measure and %0d calibration samples, %0d words checked,",
             n_measure, n_cal, n_results);
    $display("%0d calibration runs finished across %0d register settings.",
             n_cal_runs, 6);
    if (errors == 0 && expected_outputs.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // run limit
  initial begin
    #20000000;
    $display("Timeout with %0d words still expected", expected_outputs.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
src/itdc_pkg.sv
src/itdc_cordic.sv
src/itdc_div.sv
src/itdc_ctrl.sv
src/itdc_dp.sv
src/imu_tilt_deadband_calibrated.sv
test/testbench.sv
